[design/i2cmbe_pkg.sv]
package i2cmbe_pkg;

  // command queue depth between decode and sequencer
  localparam int QueueDepth = 2;

  localparam logic [15:0] PhaseCyclesReset = 16'd500;
  localparam logic [2:0]  BitMsb           = 3'd7;

  // register indexes on the config port
  typedef enum logic [0:0] {
    REG_PHASE_CYCLES = 1'b0,
    REG_UNUSED       = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_ACK   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
    logic       ack;
  } cmd_entry_t;

  // queue head as seen by the sequencer
  typedef struct packed {
    logic       valid;
    cmd_entry_t entry;
  } queue_head_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic drive;
    logic ack;
    logic last;
  } phase_t;

  // bus levels for one phase of a command
  // lead: leading SCL-low phase of a byte write
  // sub:  phase within the current bit (or within start/stop/ack)
  // bitn: byte bit being sent
  function automatic phase_t phase_of(cmd_entry_t e, logic lead, logic [1:0] sub,
                                      logic [2:0] bitn);
    phase_t p;
    p = '{scl: 1'b0, sda: 1'b1, drive: 1'b1, ack: 1'b0, last: 1'b0};
    case (e.cmd)
      CMD_START: begin
        p.scl  = (sub != 2'd2);
        p.sda  = (sub == 2'd0);
        p.last = (sub == 2'd2);
      end
      CMD_STOP: begin
        p.scl  = 1'b1;
        p.sda  = (sub == 2'd1);
        p.last = (sub == 2'd1);
      end
      CMD_WRITE: begin
        if (lead) begin
          p.scl = 1'b0;
          p.sda = 1'b0;
        end else begin
          p.scl  = (sub == 2'd1);
          p.sda  = e.data[bitn];
          p.last = (bitn == 3'd0) && (sub == 2'd2);
        end
      end
      CMD_ACK: begin
        // SDA released: pulled-up line reads high
        p.scl   = (sub == 2'd0);
        p.sda   = 1'b1;
        p.drive = 1'b0;
        p.ack   = (sub == 2'd1) ? e.ack : 1'b0;
        p.last  = (sub == 2'd1);
      end
      default: begin
        p.last = 1'b1;
      end
    endcase
    return p;
  endfunction

endpackage

[design/i2cmbe_front.sv]
module i2cmbe_front #(
  parameter int DEPTH = 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_operation,
  input  logic [7:0]              in_data_byte,
  input  logic                    in_sda_level,
  output i2cmbe_pkg::queue_head_t head,
  input  logic                    pop
);
  import i2cmbe_pkg::*;

  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  cmd_entry_t            q_r [DEPTH];
  logic [IdxW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [IdxW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]       count_r, count_nxt;
  logic                  push;
  cmd_entry_t            decoded;

  // decode: ack sample only matters for an ack command
  always_comb begin
    decoded.cmd  = cmd_t'(in_operation);
    decoded.data = in_data_byte;
    decoded.ack  = (cmd_t'(in_operation) == CMD_ACK) & in_sda_level;
  end

  assign in_stall = (count_r == CntW'(DEPTH));
  assign push     = in_valid && !in_stall;

  assign head.valid = (count_r != '0);
  assign head.entry = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == IdxW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == IdxW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= decoded;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(DEPTH))
    else $error("queue count above depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("pop from empty queue");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("push not counted");

endmodule

[design/i2cmbe_back.sv]
module i2cmbe_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  i2cmbe_pkg::queue_head_t head,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_scl_out,
  output logic                    out_sda_out,
  output logic                    out_sda_drive,
  output logic                    out_ack_bit,
  output logic                    out_last_phase
);
  import i2cmbe_pkg::*;

  logic       lead_r, lead_nxt;
  logic [1:0] sub_r, sub_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic       out_valid_r, out_valid_nxt;
  phase_t     out_r;
  phase_t     ph;
  logic       adv;

  assign ph  = phase_of(head.entry, lead_r, sub_r, bit_r);
  // output slot free or being drained this cycle
  assign adv = head.valid && (!out_valid_r || !out_stall);
  assign pop = adv && ph.last;

  always_comb begin
    lead_nxt      = lead_r;
    sub_nxt       = sub_r;
    bit_nxt       = bit_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (adv) begin
      out_valid_nxt = 1'b1;
      if (ph.last) begin
        lead_nxt = 1'b1;
        sub_nxt  = 2'd0;
        bit_nxt  = BitMsb;
      end else if (head.entry.cmd == CMD_WRITE && lead_r) begin
        lead_nxt = 1'b0;
      end else if (head.entry.cmd == CMD_WRITE && sub_r == 2'd2) begin
        sub_nxt = 2'd0;
        bit_nxt = bit_r - 1'b1;
      end else begin
        sub_nxt = sub_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r      <= 1'b1;
      sub_r       <= 2'd0;
      bit_r       <= BitMsb;
      out_valid_r <= 1'b0;
    end else begin
      lead_r      <= lead_nxt;
      sub_r       <= sub_nxt;
      bit_r       <= bit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= ph;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_scl_out    = out_r.scl;
  assign out_sda_out    = out_r.sda;
  assign out_sda_drive  = out_r.drive;
  assign out_ack_bit    = out_r.ack;
  assign out_last_phase = out_r.last;

  a_ack_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.ack) |-> (out_r.last && !out_r.drive))
    else $error("ack bit outside final ack phase");

  a_released_high: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.drive) |-> out_r.sda)
    else $error("released SDA not high");

  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_valid_r && out_r.last))
    else $error("command retired without last phase");

  a_counters_reset: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (lead_r && sub_r == 2'd0 && bit_r == BitMsb))
    else $error("phase counters not rewound");

endmodule

[design/i2c_master_bit_engine.sv]
// I2C master bit engine.
// Input channel (in_*): one bus command per transfer: start, stop, write byte
// or read acknowledge. in_sda_level is the SDA level sampled in the ack clock.
// Output channel (out_*): one transfer per half-period phase with SCL level,
// SDA level, SDA drive enable, ack bit (final ack phase only) and a last flag.
// Start gives 3 phases, stop 2, write byte 25 (MSB first), read ack 2.
// When the queue is empty, a command passes through its queue entry and then
// the output phase register before its first phase shows on out_valid.
// Throughput is one phase per cycle while out_stall is low; queued commands
// follow each other with no gap between their phase runs.
// A small command queue decouples decode from the phase sequencer, so input
// transfers are taken while a phase waits on a stalled output; in_stall rises
// only when the queue is full. out_stall holds the output phase register.
// cfg_* is an APB-style port holding phase_cycles (index 0, reset 500), the
// per-phase hold time for the pin driver; it does not change phase contents.
// Reset (rst_n low, synchronous) empties the queue, drops out_valid and
// rewinds the sequencer; phase_cycles returns to 500.
module i2c_master_bit_engine #(
  parameter int QUEUE_DEPTH = i2cmbe_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_data_byte,
  input  logic        in_sda_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_scl_out,
  output logic        out_sda_out,
  output logic        out_sda_drive,
  output logic        out_ack_bit,
  output logic        out_last_phase,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import i2cmbe_pkg::*;

  queue_head_t head;
  logic        pop;
  logic [15:0] phase_cycles_r, phase_cycles_nxt;
  reg_idx_t    reg_idx;
  logic        cfg_wr;

  // register index is the word address
  assign reg_idx    = reg_idx_t'(cfg_paddr[2]);
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    phase_cycles_nxt = phase_cycles_r;
    if (cfg_wr && reg_idx == REG_PHASE_CYCLES) begin
      phase_cycles_nxt = cfg_pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_cycles_r <= PhaseCyclesReset;
    end else begin
      phase_cycles_r <= phase_cycles_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PHASE_CYCLES: cfg_prdata = {16'd0, phase_cycles_r};
      default:          cfg_prdata = 32'd0;
    endcase
  end

  // decode and command queue
  i2cmbe_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_data_byte (in_data_byte),
    .in_sda_level (in_sda_level),
    .head         (head),
    .pop          (pop)
  );

  // phase sequencer with registered output
  i2cmbe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_scl_out    (out_scl_out),
    .out_sda_out    (out_sda_out),
    .out_sda_drive  (out_sda_drive),
    .out_ack_bit    (out_ack_bit),
    .out_last_phase (out_last_phase)
  );

endmodule
